// ===== design/string_to_integer_parser_defines.svh =====
// Assertion macros shared by the string-to-integer parser modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef STRING_TO_INTEGER_PARSER_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STIP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STIP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/stip_pkg.sv =====
// Package for the string-to-integer parser: types, character codes and helpers.
// No dependencies; every module and interface of the block imports it.
package stip_pkg;

  localparam int unsigned ValW    = 64;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned OffW    = 16;
  localparam int unsigned DigW    = 6;
  localparam int unsigned ProdW   = ValW + BaseW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 6;

  localparam logic [OffW-1:0]    MaxOffset = 16'hFFFF;
  localparam logic [ValW-1:0]    SMax      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [BaseW-1:0]   MaxBase   = 6'd36;
  localparam logic [BaseW-1:0]   Base2     = 6'd2;
  localparam logic [BaseW-1:0]   Base8     = 6'd8;
  localparam logic [BaseW-1:0]   Base10    = 6'd10;
  localparam logic [BaseW-1:0]   Base16    = 6'd16;

  localparam logic [CfgIdxW-1:0] CfgBase   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLzo    = 2'd1;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowZ   = 8'h7A;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpZ    = 8'h5A;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChX      = 8'h78;
  localparam logic [7:0] ChO      = 8'h6F;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] LowBias  = 8'd87;
  localparam logic [7:0] UpBias   = 8'd55;

  typedef enum logic [4:0] {
    PhStart     = 5'b00001,
    PhAfterSign = 5'b00010,
    PhAutoZero  = 5'b00100,
    PhExplZero  = 5'b01000,
    PhDigits    = 5'b10000
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [ValW-1:0] acc;
    logic            neg;
    logic            ovf;
    logic            dig;
    logic [BaseW-1:0] abase;
    logic [OffW-1:0] cnt;
    logic [OffW-1:0] roff;
  } state_t;

  typedef struct packed {
    logic            skip;
    logic            bad;
    logic [DigW-1:0] val;
  } digit_t;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   overflow;
    logic                   has_digits;
    logic [OffW-1:0]        end_offset;
    logic [BaseW-1:0]       base_used;
  } result_t;

  localparam state_t StateInit = '{
    phase: PhStart, acc: '0, neg: 1'b0, ovf: 1'b0, dig: 1'b0,
    abase: '0, cnt: '0, roff: '0
  };

  // Saturating character count.
  function automatic logic [OffW-1:0] bump(input logic [OffW-1:0] cnt);
    logic [OffW-1:0] r;
    r = cnt;
    if (cnt != MaxOffset) begin
      r = cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [BaseW-1:0] clamp_base(input logic [BaseW-1:0] b);
    logic [BaseW-1:0] r;
    r = (b > MaxBase) ? MaxBase : b;
    return r;
  endfunction

endpackage

// ===== design/stip_ifs.sv =====
// Handshake channel interfaces of the string-to-integer parser.
// Depends on stip_pkg for field widths.
interface stip_ch_if import stip_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface stip_res_if import stip_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] value;
  logic                   overflow;
  logic                   has_digits;
  logic [OffW-1:0]        end_offset;
  logic [BaseW-1:0]       base_used;
  modport source (output valid, output value, output overflow, output has_digits,
                  output end_offset, output base_used, input ready);
  modport sink   (input valid, input value, input overflow, input has_digits,
                  input end_offset, input base_used, output ready);
endinterface

interface stip_cfg_if import stip_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] idx;
  logic [CfgDatW-1:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== design/stip_digit.sv =====
// Character classifier: digit value, underscore skip mark, or non-digit.
// Depends on stip_pkg.
module stip_digit import stip_pkg::*; (
  input  logic [7:0] ch_i,
  output digit_t     digit_o
);

  logic [7:0] diff;

  always_comb begin
    diff          = 8'd0;
    digit_o.skip  = 1'b0;
    digit_o.bad   = 1'b0;
    if (ch_i inside {[ChZero:ChNine]}) begin
      diff = ch_i - ChZero;
    end else if (ch_i inside {[ChLowA:ChLowZ]}) begin
      diff = ch_i - LowBias;
    end else if (ch_i inside {[ChUpA:ChUpZ]}) begin
      diff = ch_i - UpBias;
    end else if (ch_i == ChUnder) begin
      digit_o.skip = 1'b1;
    end else begin
      digit_o.bad = 1'b1;
    end
    digit_o.val = diff[DigW-1:0];
  end

endmodule

// ===== design/stip_step.sv =====
// Per-character parse step: next state and the optional result of one character.
// Depends on stip_pkg and stip_digit.
module stip_step import stip_pkg::*; (
  input  state_t          state_i,
  input  logic [7:0]      ch_i,
  input  logic [BaseW-1:0] base_i,
  input  logic            lzo_i,
  output state_t          state_o,
  output logic            emit_o,
  output result_t         result_o
);

  digit_t           dgt;
  logic [ProdW-1:0] prod;
  logic             do_after;
  logic             do_take;
  state_t           s;

  stip_digit u_digit (
    .ch_i    (ch_i),
    .digit_o (dgt)
  );

  always_comb begin
    s        = state_i;
    do_after = 1'b0;
    do_take  = 1'b0;
    emit_o   = 1'b0;
    result_o = '0;
    prod     = '0;

    case (state_i.phase)
      PhStart: begin
        s.abase = clamp_base(base_i);
        if (ch_i == ChMinus || ch_i == ChPlus) begin
          s.neg   = (ch_i == ChMinus);
          s.cnt   = bump(s.cnt);
          s.phase = PhAfterSign;
        end else begin
          do_after = 1'b1;
        end
      end
      PhAfterSign: begin
        do_after = 1'b1;
      end
      PhAutoZero: begin
        if (ch_i == ChX || ch_i == ChO || ch_i == ChB) begin
          s.abase = (ch_i == ChX) ? Base16 : (ch_i == ChO) ? Base8 : Base2;
          s.cnt   = bump(s.cnt);
          s.phase = PhDigits;
        end else begin
          s.abase = lzo_i ? Base8 : Base10;
          s.roff  = s.cnt;
          do_take = 1'b1;
        end
      end
      PhExplZero: begin
        if ((s.abase == Base16 && ch_i == ChX) || (s.abase == Base8 && ch_i == ChO) ||
            (s.abase == Base2 && ch_i == ChB)) begin
          s.dig   = 1'b0;
          s.cnt   = bump(s.cnt);
          s.phase = PhDigits;
        end else begin
          do_take = 1'b1;
        end
      end
      default: begin
        do_take = 1'b1;
      end
    endcase

    // Sign handled: resolve auto base or an explicit-base leading zero.
    if (do_after) begin
      if (s.abase == '0) begin
        if (ch_i == ChZero) begin
          s.cnt   = bump(s.cnt);
          s.phase = PhAutoZero;
        end else begin
          s.abase = Base10;
          do_take = 1'b1;
        end
      end else if ((s.abase == Base2 || s.abase == Base8 || s.abase == Base16) &&
                   ch_i == ChZero) begin
        s.dig   = 1'b1;
        s.acc   = '0;
        s.cnt   = bump(s.cnt);
        s.phase = PhExplZero;
      end else begin
        do_take = 1'b1;
      end
    end

    if (do_take) begin
      s.phase = PhDigits;
      if (dgt.skip) begin
        s.cnt = bump(s.cnt);
      end else if (dgt.bad || dgt.val >= s.abase || s.abase == '0) begin
        emit_o = 1'b1;
        if (s.ovf) begin
          result_o.value = SMax;
        end else if (s.neg) begin
          result_o.value = ValW'(0) - s.acc;
        end else begin
          result_o.value = s.acc;
        end
        result_o.overflow   = s.ovf;
        result_o.has_digits = s.dig;
        result_o.end_offset = s.dig ? s.cnt : s.roff;
        result_o.base_used  = s.abase;
        s = StateInit;
      end else begin
        // acc*b + d is formed at full width and compared against the signed maximum.
        s.dig = 1'b1;
        prod  = ({{BaseW{1'b0}}, s.acc} * {{ValW{1'b0}}, s.abase}) +
                {{(ProdW-DigW){1'b0}}, dgt.val};
        if (prod > {{BaseW{1'b0}}, SMax}) begin
          s.ovf = 1'b1;
        end
        if (!s.ovf) begin
          s.acc = prod[ValW-1:0];
        end
        s.cnt = bump(s.cnt);
      end
    end

    state_o = s;
  end

endmodule

// ===== design/string_to_integer_parser.sv =====
// An accepted character is held in the input register, then moves on into the parse state and output register.
// Throughput: one character per cycle, but a string-ending character waits on a pending output.
// The per-character multiply-add of one accumulator is the only arithmetic work.
// Reset (rst_ni low, asynchronous) clears the parse state to its start phase and the base and octal option to zero.
// No clearing pass is needed after reset.
`include "string_to_integer_parser_defines.svh"

module string_to_integer_parser import stip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  stip_ch_if.sink    in_if,
  stip_res_if.source out_if,
  stip_cfg_if.sink   cfg_if
);

  // Configuration registers. Writes must arrive only while the parser is idle; the block
  // does not enforce this. The base is sampled directly when a string's first character is processed.
  logic [BaseW-1:0] base_q;
  logic             lzo_q;

  // Input register: one accepted character waiting to be processed.
  logic             in_vld_q;
  logic [7:0]       ch_q;

  // Parse state across the characters of one string.
  state_t           state_q;
  state_t           state_d;

  // Output register holding one result transaction.
  logic             out_vld_q;
  result_t          res_q;
  result_t          res_d;

  logic             emit;
  logic             advance;
  logic             in_acc;

  stip_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_q),
    .base_i   (base_q),
    .lzo_i    (lzo_q),
    .state_o  (state_d),
    .emit_o   (emit),
    .result_o (res_d)
  );

  // The held character moves on unless it ends a string while the output
  // register still holds a result that the sink has not taken.
  assign advance     = in_vld_q && (!emit || !out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;
  assign in_acc      = in_if.valid && in_if.ready;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      lzo_q  <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.idx)
        CfgBase: begin
          base_q <= cfg_if.data;
        end
        CfgLzo: begin
          lzo_q <= cfg_if.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= StateInit;
    end else begin
      if (in_if.ready) begin
        in_vld_q <= in_if.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q <= in_if.ch;
    end
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.value      = res_q.value;
  assign out_if.overflow   = res_q.overflow;
  assign out_if.has_digits = res_q.has_digits;
  assign out_if.end_offset = res_q.end_offset;
  assign out_if.base_used  = res_q.base_used;

  // A character that ends a string leaves the parser ready for a fresh string.
  `STIP_ASSERT_NXT(a_emit_restarts, advance && emit, state_q.phase == PhStart, "parse state not restarted after result")
  // The accumulator never exceeds the signed maximum, overflowed or not.
  `STIP_ASSERT_IMP(a_acc_in_range, 1'b1, !state_q.acc[ValW-1], "accumulator above signed maximum")
  // Overflow can only follow accepted digits.
  `STIP_ASSERT_IMP(a_ovf_has_digits, state_q.ovf, state_q.dig, "overflow without digits")
  // A held character that cannot move on stays in the input register.
  `STIP_ASSERT_NXT(a_hold_char, in_vld_q && !advance, in_vld_q && $stable(ch_q), "stalled character lost")

endmodule
